// ===== rtl/core/input_event_ring_queue_core_assert.svh =====
// assertion macros used by the event queue rtl
`ifndef INPUT_EVENT_RING_QUEUE_CORE_ASSERT_SVH
`define INPUT_EVENT_RING_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IERQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IERQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ierq_pkg.sv =====
// types, codes and event packing for the input event ring queue
`timescale 1ns / 1ps
package ierq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;

  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 128;
  localparam int EVENT_W    = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [1:0] CMD_KEY    = 2'd0;
  localparam logic [1:0] CMD_MOUSE  = 2'd1;
  localparam logic [1:0] CMD_POLL   = 2'd2;
  localparam logic [1:0] CMD_SERIAL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_TYPE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MOUSE_TYPE = 1'b1;

  localparam logic [7:0] KEY_TYPE_RST   = 8'd1;
  localparam logic [7:0] MOUSE_TYPE_RST = 8'd2;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef struct packed {
    logic valid;
    logic present;
  } poll_t;

  function automatic logic [EVENT_W-1:0] pack_event(
    input logic [1:0]  cmd,
    input logic [7:0]  key_type,
    input logic [7:0]  mouse_type,
    input logic [23:0] key_code,
    input logic [31:0] key_value,
    input logic [15:0] delta_x,
    input logic [15:0] delta_y,
    input logic [23:0] button_bits
  );
    logic [7:0] ch;
    logic [EVENT_W-1:0] word;
    ch = key_code[7:0];
    if (ch == CHAR_CR) begin
      ch = CHAR_LF;
    end
    case (cmd)
      CMD_MOUSE:  word = {mouse_type, button_bits, delta_y, delta_x};
      CMD_SERIAL: word = {key_type, 16'd0, ch, 32'd1};
      default:    word = {key_type, key_code, key_value};
    endcase
    return word;
  endfunction

endpackage

// ===== rtl/core/input_event_ring_queue_core.sv =====
// top level of the input event ring queue
// usage:
//   input words enter on s_axis; tuser carries the command (push key, push mouse,
//   poll, push serial character), tdata the payload fields.
//   each poll gives one output word on m_axis; pushes give none. an empty-queue
//   poll gives a word with the present flag and all fields zero.
//   a push into a full queue drops the oldest event.
//   a poll result is registered in the store read register, then in the
//   output register.
//   throughput: one word per cycle on the input while results are taken.
//   the store read register and the output register hold up to two results;
//   when the receiver stalls with both full, s_axis_tready drops until it
//   takes the waiting word.
//   reset empties the queue and sets the type registers to 1 (key) and 2
//   (mouse); store contents stay as they were and are never read unwritten.
//   cfg_we writes cfg_data to the register at cfg_index; the write is registered.
`timescale 1ns / 1ps
module input_event_ring_queue_core import ierq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // key_code, key_value, delta_x, delta_y, button_bits
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // event_type, event_code, event_value, packed_event
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // event_present
  output logic                  m_axis_tuser
);

  logic [7:0]         key_type_code;
  logic [7:0]         mouse_type_code;
  logic               accept, push_en, pop_req;
  logic [EVENT_W-1:0] push_word;
  logic [EVENT_W-1:0] rd_word;
  poll_t              poll;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_type_code   <= KEY_TYPE_RST;
      mouse_type_code <= MOUSE_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_TYPE:   key_type_code   <= cfg_data;
        REG_MOUSE_TYPE: mouse_type_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign pop_req = accept && (s_axis_tuser == CMD_POLL);
  assign push_en = accept && (s_axis_tuser != CMD_POLL);

  assign push_word = pack_event(s_axis_tuser, key_type_code, mouse_type_code,
                                s_axis_tdata[23:0], s_axis_tdata[55:24],
                                s_axis_tdata[71:56], s_axis_tdata[87:72],
                                s_axis_tdata[111:88]);

  ierq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .push_en  (push_en),
    .pop_req  (pop_req),
    .push_word(push_word),
    .poll     (poll),
    .rd_word  (rd_word)
  );

  ierq_out u_out (
    .clk        (clk),
    .rst        (rst),
    .poll       (poll),
    .rd_word    (rd_word),
    .in_ready   (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_present(m_axis_tuser),
    .out_data   (m_axis_tdata)
  );

endmodule

// ===== rtl/core/ierq_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module ierq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ierq_ctrl.sv =====
// ring pointers, fill count and event store
`timescale 1ns / 1ps
module ierq_ctrl import ierq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_en,
  input  logic               pop_req,
  input  logic [EVENT_W-1:0] push_word,
  output poll_t              poll,
  output logic [EVENT_W-1:0] rd_word
);

  `include "input_event_ring_queue_core_assert.svh"

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic             empty, full, pop_en;
  logic [PTR_W-1:0] rp_inc, wp_inc;

  assign empty  = (fill_count == '0);
  assign full   = (fill_count == CNT_FULL);
  assign pop_en = pop_req && !empty;
  assign rp_inc = (read_pointer == PTR_LAST) ? '0 : read_pointer + PTR_W'(1);
  assign wp_inc = (write_pointer == PTR_LAST) ? '0 : write_pointer + PTR_W'(1);

  assign poll.valid   = pop_req;
  assign poll.present = !empty;

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    fill_count_next    = fill_count;
    if (push_en) begin
      write_pointer_next = wp_inc;
      if (full) begin
        read_pointer_next = rp_inc;
      end else begin
        fill_count_next = fill_count + CNT_W'(1);
      end
    end else if (pop_en) begin
      read_pointer_next = rp_inc;
      fill_count_next   = fill_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
    end else begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      fill_count    <= fill_count_next;
    end
  end

  ierq_ram #(
    .WIDTH(EVENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (push_en),
    .waddr(write_pointer),
    .wdata(push_word),
    .re   (pop_en),
    .raddr(read_pointer),
    .rdata(rd_word)
  );

  `IERQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= CNT_FULL,
    "fill count above queue depth")
  `IERQ_ASSERT_NOW(a_empty_ptrs, empty, read_pointer == write_pointer,
    "pointers differ on empty queue")
  `IERQ_ASSERT_NOW(a_full_ptrs, full, read_pointer == write_pointer,
    "pointers differ on full queue")
  `IERQ_ASSERT_NEXT(a_overwrite, push_en && full, full && read_pointer == write_pointer,
    "push into full queue lost the full state")

endmodule

// ===== rtl/core/ierq_out.sv =====
// read-data stage and output register for poll results
`timescale 1ns / 1ps
module ierq_out import ierq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  poll_t                 poll,
  input  logic [EVENT_W-1:0]    rd_word,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_present,
  output logic [OUT_DATA_W-1:0] out_data
);

  poll_t              stage;
  logic               out_free;
  logic [EVENT_W-1:0] word;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !(stage.valid && !out_free);
  assign word     = stage.present ? rd_word : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!stage.valid || out_free) begin
        stage <= poll;
      end
      if (out_free) begin
        out_valid <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage.valid) begin
      out_present <= stage.present;
      out_data    <= {word, word[31:0], word[55:32], word[63:56]};
    end
  end

endmodule
